### hw/rtl/iep_pkg.sv
// Shared types and constants of the indexed event priority heap.
// Depends on nothing; the top level imports it.
`default_nettype none

package iep_pkg;

   localparam int SLOT_W  = 10;
   localparam int PRIO_W  = 8;
   localparam int STAMP_W = 32;
   localparam int POSN_W  = 11;

   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]               operation;
      logic [SLOT_W-1:0]        slot;
      logic signed [PRIO_W-1:0] priority_req;
      logic [STAMP_W-1:0]       stamp;
   } req_payload_type;

   typedef struct packed {
      logic                     found;
      logic [SLOT_W-1:0]        out_slot;
      logic signed [PRIO_W-1:0] out_priority;
      logic [STAMP_W-1:0]       out_stamp;
      logic [POSN_W-1:0]        position;
      logic [POSN_W-1:0]        queued_count;
   } rsp_payload_type;

   // One heap entry carries its slot together with the slot's key.
   typedef struct packed {
      logic [SLOT_W-1:0]        slot;
      logic signed [PRIO_W-1:0] prio;
      logic [STAMP_W-1:0]       stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS_WT,
      ST_HEAD_WT,
      ST_TAIL_WT,
      ST_DOWN,
      ST_DL_WT,
      ST_DR_WT,
      ST_DEC,
      ST_UP,
      ST_UP_WT
   } state_type;

   // True when entry a must be served after entry b.
   function automatic logic later(entry_type a, entry_type b);
      logic r;
      if (a.prio != b.prio) begin
         r = (a.prio > b.prio);
      end else begin
         r = (a.stamp > b.stamp);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/iep_chan_if.sv
// Valid/ready channel carrying one payload per transaction.
// Depends on nothing; the payload type is passed in as a type parameter.
`default_nettype none

interface iep_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/iep_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; used for the heap store and the slot position store.
`default_nettype none

module iep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

### hw/rtl/indexed_event_priority_heap.sv
// Top level of the indexed event priority heap: sequencer and two memories.
// Depends on iep_pkg, iep_chan_if and iep_ram.
//
//   channel   direction  payload            transaction when
//   req_chan  in         req_payload_type   valid && ready
//   rsp_chan  out        rsp_payload_type   valid && ready
//
// Each transaction is handled alone. A lookup reads the position store or the
// heap head, a level of sift-down reads the left child, reads the right child,
// picks and moves, and a level of sift-up reads the parent and moves; the single
// read port of the heap memory makes these reads follow one another.
// After reset a clearing pass writes zero to all SLOTS position entries, one a
// cycle, before the first request is taken.
// A finished response waits in an output register; the next request is taken
// in the cycle that response leaves.
`default_nettype none

module indexed_event_priority_heap #(
   parameter int SLOTS = 1024
) (
   input logic         clock,
   input logic         reset,
   iep_chan_if.sink    req_chan,
   iep_chan_if.source  rsp_chan
);
   import iep_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int PW = $clog2(SLOTS + 1);
   localparam logic [PW-1:0] SLOTS_P = PW'(SLOTS);
   localparam logic [AW-1:0] LAST_A  = AW'(SLOTS - 1);
   localparam logic [PW-1:0] ONE_P   = PW'(1);

   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [PW-1:0]   count_ff, count_in;
   logic [1:0]      op_ff, op_in;
   entry_type       x_ff, x_in;     // entry being placed (new key or moved tail)
   entry_type       a_ff, a_in;     // left child
   entry_type       c_ff, c_in;     // chosen child
   logic [PW-1:0]   i_ff, i_in;     // current hole position
   logic [PW-1:0]   n_ff, n_in;     // heap size bound for the sift-down
   logic [PW-1:0]   j_ff, j_in;     // left child position
   logic [PW-1:0]   cj_ff, cj_in;   // chosen child position
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic            heap_we;
   logic [AW-1:0]   heap_waddr, heap_raddr;
   entry_type       heap_wdata, heap_rd;
   logic [ENTRY_W-1:0] heap_rdata;
   logic            pos_we;
   logic [AW-1:0]   pos_waddr, pos_raddr;
   logic [PW-1:0]   pos_wdata, pos_rdata;

   logic            accept;
   logic            done;
   logic [PW:0]     j_wide;
   entry_type       b_pick;
   logic            pick_right;

   // Heap store, indexed by heap position minus one.
   iep_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_heap_ram (
      .clock (clock),
      .we    (heap_we),
      .waddr (heap_waddr),
      .wdata (heap_wdata),
      .raddr (heap_raddr),
      .rdata (heap_rdata)
   );

   // Position of each slot in the heap, zero when the slot is not queued.
   iep_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (pos_waddr),
      .wdata (pos_wdata),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   assign heap_rd = entry_type'(heap_rdata);

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   assign j_wide     = {i_ff, 1'b0};
   assign b_pick     = heap_rd;
   assign pick_right = later(a_ff, b_pick);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      x_ff   <= x_in;
      a_ff   <= a_in;
      c_ff   <= c_in;
      i_ff   <= i_in;
      n_ff   <= n_in;
      j_ff   <= j_in;
      cj_ff  <= cj_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      i_in         = i_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      cj_in        = cj_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      done         = 1'b0;

      heap_we    = 1'b0;
      heap_waddr = AW'(i_ff - ONE_P);
      heap_wdata = x_ff;
      heap_raddr = '0;
      pos_we     = 1'b0;
      pos_waddr  = AW'(x_ff.slot);
      pos_wdata  = i_ff;
      pos_raddr  = AW'(req_chan.payload.slot);

      unique case (state_ff)
         ST_CLEAR: begin
            pos_we    = 1'b1;
            pos_waddr = clr_ff;
            pos_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_A) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               op_in        = req_chan.payload.operation;
               x_in.slot    = req_chan.payload.slot;
               x_in.prio    = req_chan.payload.priority_req;
               x_in.stamp   = req_chan.payload.stamp;
               rsp_in       = '0;
               if (req_chan.payload.operation == OP_PUT ||
                   req_chan.payload.operation == OP_REMOVE) begin
                  rsp_in.out_slot = req_chan.payload.slot;
               end
               if (req_chan.payload.operation == OP_POP) begin
                  if (count_ff == '0) begin
                     done = 1'b1;
                  end else begin
                     state_in = ST_HEAD_WT;
                  end
               end else if ((req_chan.payload.operation == OP_PUT ||
                             req_chan.payload.operation == OP_REMOVE) &&
                            int'(req_chan.payload.slot) < SLOTS) begin
                  state_in = ST_POS_WT;
               end else begin
                  // Unknown operation or out-of-range slot: nothing changes.
                  done = 1'b1;
               end
            end
         end

         ST_POS_WT: begin
            if (op_ff == OP_PUT) begin
               if (pos_rdata != '0) begin
                  i_in     = pos_rdata;
                  n_in     = count_ff;
                  state_in = ST_DOWN;
               end else if (count_ff < SLOTS_P) begin
                  count_in = count_ff + ONE_P;
                  i_in     = count_ff + ONE_P;
                  state_in = ST_UP;
               end else begin
                  done = 1'b1;
               end
            end else begin
               if (pos_rdata == '0) begin
                  done = 1'b1;
               end else begin
                  pos_we        = 1'b1;
                  pos_wdata     = '0;
                  i_in          = pos_rdata;
                  n_in          = count_ff;
                  count_in      = count_ff - ONE_P;
                  rsp_in.found  = 1'b1;
                  state_in      = ST_DOWN;
               end
            end
         end

         ST_HEAD_WT: begin
            rsp_in.found        = 1'b1;
            rsp_in.out_slot     = heap_rd.slot;
            rsp_in.out_priority = heap_rd.prio;
            rsp_in.out_stamp    = heap_rd.stamp;
            pos_we              = 1'b1;
            pos_waddr           = AW'(heap_rd.slot);
            pos_wdata           = '0;
            count_in            = count_ff - ONE_P;
            n_in                = count_ff - ONE_P;
            if (count_ff == ONE_P) begin
               done = 1'b1;
            end else begin
               heap_raddr = AW'(count_ff - ONE_P);
               state_in   = ST_TAIL_WT;
            end
         end

         ST_TAIL_WT: begin
            x_in = heap_rd;
            if (op_ff == OP_POP) begin
               i_in     = ONE_P;
               state_in = ST_DOWN;
            end else begin
               state_in = ST_UP;
            end
         end

         ST_DOWN: begin
            if (j_wide > {1'b0, n_ff}) begin
               // The hole has reached a leaf.
               if (op_ff == OP_POP) begin
                  heap_we   = 1'b1;
                  pos_we    = 1'b1;
                  done      = 1'b1;
               end else if (op_ff == OP_PUT) begin
                  state_in = ST_UP;
               end else if (i_ff < n_ff) begin
                  heap_raddr = AW'(n_ff - ONE_P);
                  state_in   = ST_TAIL_WT;
               end else begin
                  done = 1'b1;
               end
            end else begin
               j_in       = j_wide[PW-1:0];
               heap_raddr = AW'(j_wide - (PW+1)'(1));
               state_in   = ST_DL_WT;
            end
         end

         ST_DL_WT: begin
            a_in = heap_rd;
            if (j_ff < n_ff) begin
               heap_raddr = AW'(j_ff);
               state_in   = ST_DR_WT;
            end else begin
               c_in     = heap_rd;
               cj_in    = j_ff;
               state_in = ST_DEC;
            end
         end

         ST_DR_WT: begin
            c_in     = pick_right ? b_pick : a_ff;
            cj_in    = pick_right ? j_ff + ONE_P : j_ff;
            state_in = ST_DEC;
         end

         ST_DEC: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
            if (op_ff == OP_POP && !later(x_ff, c_ff)) begin
               done = 1'b1;
            end else begin
               heap_wdata = c_ff;
               pos_waddr  = AW'(c_ff.slot);
               i_in       = cj_ff;
               state_in   = ST_DOWN;
            end
         end

         ST_UP: begin
            if (i_ff > ONE_P) begin
               heap_raddr = AW'((i_ff >> 1) - ONE_P);
               state_in   = ST_UP_WT;
            end else begin
               heap_we = 1'b1;
               pos_we  = 1'b1;
               done    = 1'b1;
            end
         end

         ST_UP_WT: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
            if (!later(heap_rd, x_ff)) begin
               done = 1'b1;
            end else begin
               heap_wdata = heap_rd;
               pos_waddr  = AW'(heap_rd.slot);
               i_in       = i_ff >> 1;
               state_in   = ST_UP;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         if (op_ff == OP_PUT && state_ff != ST_IDLE && state_ff != ST_POS_WT) begin
            rsp_in.found    = 1'b1;
            rsp_in.position = POSN_W'(i_ff);
         end
         rsp_in.queued_count = POSN_W'(count_in);
         rsp_valid_in        = 1'b1;
         state_in            = ST_IDLE;
      end
   end

   // The queue never holds more entries than there are slots.
   assert property (@(posedge clock) disable iff (reset) count_ff <= SLOTS_P)
      else $error("queued count exceeds slot count");

   // A response is only ever pending while the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff)
      else $error("response pending while an operation is in flight");

   // No request is taken during the clearing pass.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_chan.ready)
      else $error("request taken during clearing pass");

   // A reported heap position lies within the queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.position != '0 |->
         rsp_ff.found && rsp_ff.position <= rsp_ff.queued_count)
      else $error("reported position outside the queue");

endmodule

`default_nettype wire
